// ===== hdl/assert_macros.svh =====
// assertion macros used by the converter rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/b7s_pkg.sv =====
// shared constants, types and segment encoding for the seven-segment converter
package b7s_pkg;

    localparam int VALUE_W    = 16;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 4;
    localparam int SEG_W      = 8;
    localparam int CNT_W      = $clog2(VALUE_W);

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    localparam logic FUNC_PRINT = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // active-low segments, a on bit 0 through g on bit 6
    function automatic logic [SEG_W-1:0] seg_encode(input digit_t d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/b7s_digit_cell.sv =====
// one bcd digit of the shift-and-add converter chain
module b7s_digit_cell
(
    input  logic                clk,
    input  b7s_pkg::cell_ctrl_t ctrl,
    input  logic                bit_in,
    output logic                bit_out,
    output b7s_pkg::digit_t     digit
);

    b7s_pkg::digit_t digit_reg;
    b7s_pkg::digit_t digit_next;
    b7s_pkg::digit_t adj;

    // add 3 before the shift when the digit would pass 9
    always_comb
    begin
        adj = (digit_reg >= b7s_pkg::digit_t'(5)) ? digit_reg + b7s_pkg::digit_t'(3)
                                                  : digit_reg;
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[b7s_pkg::DIGIT_W-2:0], bit_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[b7s_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

endmodule

// ===== hdl/binary_to_seven_segment_digits.sv =====
// Four-digit seven-segment converter: each transfer on the input (func, value) yields one
// transfer of four active-low segment patterns. A print request shows value modulo 10000
// with leading zeros blanked (0xFF) and a single '0' for zero; a clear request blanks all
// four digits. The value goes through shift-and-add in a row of four bcd digit cells, one
// input bit per cycle, and is then encoded into the output register. Items are taken one at
// a time; the next item is taken while a finished result still waits on out_stall.
`include "assert_macros.svh"

module binary_to_seven_segment_digits
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [b7s_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [b7s_pkg::SEG_W-1:0]    seg_thousands,
    output logic [b7s_pkg::SEG_W-1:0]    seg_hundreds,
    output logic [b7s_pkg::SEG_W-1:0]    seg_tens,
    output logic [b7s_pkg::SEG_W-1:0]    seg_ones
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    localparam logic [b7s_pkg::CNT_W-1:0] CNT_LAST = b7s_pkg::CNT_W'(b7s_pkg::VALUE_W - 1);

    logic [1:0]                    state_reg, state_next;
    logic [b7s_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [b7s_pkg::VALUE_W-1:0]   shift_reg, shift_next;
    logic                          func_reg, func_next;
    logic                          out_valid_reg, out_valid_next;
    logic [b7s_pkg::SEG_W-1:0]     thou_reg, hund_reg, tens_reg, ones_reg;

    logic                          in_xfer;
    logic                          emit;
    b7s_pkg::cell_ctrl_t           ctrl;
    logic [b7s_pkg::NUM_DIGITS:0]  chain;
    b7s_pkg::digit_t               digits [b7s_pkg::NUM_DIGITS];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    assign ctrl.clear = in_xfer;
    assign ctrl.shift = (state_reg == ST_SHIFT);

    // msb first into the ones cell; carry out of thousands is dropped, giving mod 10000
    assign chain[0] = shift_reg[b7s_pkg::VALUE_W-1];

    for (genvar i = 0; i < b7s_pkg::NUM_DIGITS; i++)
    begin : g_cell
        b7s_digit_cell u_cell
        (
            .clk     (clk),
            .ctrl    (ctrl),
            .bit_in  (chain[i]),
            .bit_out (chain[i+1]),
            .digit   (digits[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        func_next      = func_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SHIFT;
                    cnt_next   = '0;
                    shift_next = value;
                    func_next  = func;
                end
            end
            ST_SHIFT:
            begin
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        func_reg  <= func_next;
        if (emit)
        begin
            if (func_reg == b7s_pkg::FUNC_CLEAR)
            begin
                thou_reg <= b7s_pkg::SEG_BLANK;
                hund_reg <= b7s_pkg::SEG_BLANK;
                tens_reg <= b7s_pkg::SEG_BLANK;
                ones_reg <= b7s_pkg::SEG_BLANK;
            end
            else
            begin
                // blank leading zeros, ones digit always shown
                thou_reg <= (digits[3] == '0) ? b7s_pkg::SEG_BLANK
                                              : b7s_pkg::seg_encode(digits[3]);
                hund_reg <= (digits[3] == '0 && digits[2] == '0) ? b7s_pkg::SEG_BLANK
                                              : b7s_pkg::seg_encode(digits[2]);
                tens_reg <= (digits[3] == '0 && digits[2] == '0 && digits[1] == '0)
                            ? b7s_pkg::SEG_BLANK : b7s_pkg::seg_encode(digits[1]);
                ones_reg <= b7s_pkg::seg_encode(digits[0]);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign seg_thousands = thou_reg;
    assign seg_hundreds  = hund_reg;
    assign seg_tens      = tens_reg;
    assign seg_ones      = ones_reg;

    `ASSERT_NEXT(a_xfer_starts_shift, clk, rst_n, in_xfer, state_reg == ST_SHIFT)
    `ASSERT_NEXT(a_emit_gives_result, clk, rst_n, emit, out_valid && state_reg == ST_IDLE)
    `ASSERT_SAME(a_cnt_only_shifting, clk, rst_n, cnt_reg != '0, state_reg == ST_SHIFT)
    `ASSERT_SAME(a_digits_bcd, clk, rst_n, state_reg == ST_EMIT,
        digits[0] <= 4'd9 && digits[1] <= 4'd9 && digits[2] <= 4'd9 && digits[3] <= 4'd9)

endmodule

// ===== test/binary_to_seven_segment_digits_checker.sv =====
// watches both channels of the seven-segment converter, predicts each result and compares it
module binary_to_seven_segment_digits_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         func,
    input  logic [b7s_pkg::VALUE_W-1:0]  value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [b7s_pkg::SEG_W-1:0]    seg_thousands,
    input  logic [b7s_pkg::SEG_W-1:0]    seg_hundreds,
    input  logic [b7s_pkg::SEG_W-1:0]    seg_tens,
    input  logic [b7s_pkg::SEG_W-1:0]    seg_ones,
    output int                           mismatches,
    output int                           outstanding,
    output int                           results_checked
);
    import b7s_pkg::*;

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [SEG_W-1:0] thousands;
        logic [SEG_W-1:0] hundreds;
        logic [SEG_W-1:0] tens;
        logic [SEG_W-1:0] ones;
    } digit_patterns_t;

    digit_patterns_t expected_patterns[$];
    logic [VALUE_W-1:0] expected_values[$];

    function automatic logic [SEG_W-1:0] digit_glyph(input int d);
        case (d)
            0:       return 8'hC0;
            1:       return 8'hF9;
            2:       return 8'hA4;
            3:       return 8'hB0;
            4:       return 8'h99;
            5:       return 8'h92;
            6:       return 8'h82;
            7:       return 8'hF8;
            8:       return 8'h80;
            9:       return 8'h90;
            default: return SEG_BLANK;
        endcase
    endfunction

    function automatic digit_patterns_t predict_patterns(input logic f,
                                                         input logic [VALUE_W-1:0] v);
        logic [SEG_W-1:0] place [NUM_DIGITS];
        digit_patterns_t  p;
        int               rest;
        int               pos;
        for (pos = 0; pos < NUM_DIGITS; pos++)
            place[pos] = SEG_BLANK;
        if (f == FUNC_PRINT)
        begin
            rest = int'(v) % 10000;
            pos  = NUM_DIGITS - 1;
            // ones place is always shown, higher places only while digits remain
            do
            begin
                place[pos] = digit_glyph(rest % 10);
                rest       = rest / 10;
                pos--;
            end
            while (rest > 0 && pos >= 0);
        end
        p.thousands = place[0];
        p.hundreds  = place[1];
        p.tens      = place[2];
        p.ones      = place[3];
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] v,
                               input logic [SEG_W-1:0] got, input logic [SEG_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h want %02h for value %0d",
                                      name, got, want, v));
    endtask

    always @(posedge clk)
    begin : watch
        digit_patterns_t    want;
        logic [VALUE_W-1:0] shown;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_patterns.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want  = expected_patterns.pop_front();
                    shown = expected_values.pop_front();
                    check_field("seg_thousands", shown, seg_thousands, want.thousands);
                    check_field("seg_hundreds", shown, seg_hundreds, want.hundreds);
                    check_field("seg_tens", shown, seg_tens, want.tens);
                    check_field("seg_ones", shown, seg_ones, want.ones);
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_patterns.push_back(predict_patterns(func, value));
                expected_values.push_back(value);
            end
        end
        outstanding = expected_patterns.size();
    end

endmodule

// ===== test/binary_to_seven_segment_digits_tb.sv =====
// stimulus, handshake pacing and verdict for the seven-segment converter
module binary_to_seven_segment_digits_tb;
    import b7s_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1130;
    localparam int MAX_WAIT     = 17;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               func      = FUNC_PRINT;
    logic [VALUE_W-1:0] value     = '0;
    logic               out_stall = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic [SEG_W-1:0]   seg_thousands;
    logic [SEG_W-1:0]   seg_hundreds;
    logic [SEG_W-1:0]   seg_tens;
    logic [SEG_W-1:0]   seg_ones;

    int mismatches;
    int outstanding;
    int results_checked;
    int cycles      = 0;
    int prints_sent = 0;
    int clears_sent = 0;
    bit steady_sender   = 1'b0;
    bit steady_receiver = 1'b0;

    binary_to_seven_segment_digits u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .seg_thousands (seg_thousands),
        .seg_hundreds  (seg_hundreds),
        .seg_tens      (seg_tens),
        .seg_ones      (seg_ones)
    );

    binary_to_seven_segment_digits_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .seg_thousands   (seg_thousands),
        .seg_hundreds    (seg_hundreds),
        .seg_tens        (seg_tens),
        .seg_ones        (seg_ones),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // offers one request and returns at the edge where it transfers
    task automatic send_request(input logic f, input logic [VALUE_W-1:0] v);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do @(posedge clk); while (in_stall);
        if (f == FUNC_CLEAR)
            clears_sent++;
        else
            prints_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = VALUE_W'($urandom_range(0, 9));
            1:       v = VALUE_W'($urandom_range(10, 99));
            2:       v = VALUE_W'($urandom_range(100, 999));
            3:       v = VALUE_W'($urandom_range(1000, 9999));
            // values that wrap to small numbers past each multiple of 10000
            4:       v = VALUE_W'($urandom_range(1, 6) * 10000 + $urandom_range(0, 120));
            default: v = VALUE_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    initial
    begin : receiver
        int wait_cycles;
        int taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            if (taken % 100 == 0)
                steady_receiver = ($urandom_range(0, 3) == 0);
            // long hold-offs so the block fills up and stalls its input
            if (taken == 200 || taken == 700)
                wait_cycles = LONG_HOLD;
            else
                wait_cycles = steady_receiver ? 0 : $urandom_range(0, MAX_WAIT);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(FUNC_PRINT, 16'd0);
        send_request(FUNC_PRINT, 16'd1);
        send_request(FUNC_PRINT, 16'd9);
        send_request(FUNC_PRINT, 16'd10);
        send_request(FUNC_PRINT, 16'd99);
        send_request(FUNC_PRINT, 16'd100);
        send_request(FUNC_PRINT, 16'd999);
        send_request(FUNC_PRINT, 16'd1000);
        send_request(FUNC_PRINT, 16'd1234);
        send_request(FUNC_PRINT, 16'd5678);
        send_request(FUNC_PRINT, 16'd9999);
        send_request(FUNC_PRINT, 16'd10000);
        send_request(FUNC_PRINT, 16'd10001);
        send_request(FUNC_PRINT, 16'd10010);
        send_request(FUNC_PRINT, 16'd12345);
        send_request(FUNC_PRINT, 16'd20000);
        send_request(FUNC_PRINT, 16'd60000);
        send_request(FUNC_PRINT, 16'd65535);
        send_request(FUNC_PRINT, 16'h5555);
        send_request(FUNC_PRINT, 16'hAAAA);
        send_request(FUNC_PRINT, 16'd4096);
        send_request(FUNC_CLEAR, 16'd0);
        send_request(FUNC_CLEAR, 16'd65535);
        send_request(FUNC_CLEAR, 16'd1234);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                steady_sender = ($urandom_range(0, 3) == 0);
            if (n == 600)
                drain_results();
            send_request(($urandom_range(0, 9) == 0) ? FUNC_CLEAR : FUNC_PRINT,
                         random_value());
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d print and %0d clear requests, checked %0d results",
                 prints_sent, clears_sent, results_checked);
        $display("with random gaps on both sides, two long output holds and idle pauses");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/b7s_pkg.sv
hdl/b7s_digit_cell.sv
hdl/binary_to_seven_segment_digits.sv
test/binary_to_seven_segment_digits_checker.sv
test/binary_to_seven_segment_digits_tb.sv
